>>> design/frac_n_synth_register_calc_unit_macros.svh
// Assertion macros shared by the register calculator RTL.
`ifndef FRAC_N_SYNTH_REGISTER_CALC_UNIT_MACROS_SVH
`define FRAC_N_SYNTH_REGISTER_CALC_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, muted while arst_n is low.
`define FNSRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, muted while arst_n is low.
`define FNSRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/fnsrc_pkg.sv
// Shared types and constants of the synthesizer register calculator.
package fnsrc_pkg;

	localparam int FreqW    = 23;
	localparam int CfgW     = 16;
	localparam int WordW    = 32;
	localparam int IdxW     = 3;
	localparam int BandW    = 3;
	localparam int DivW     = 32;
	localparam int DivCntW  = 6;
	localparam int MhzW     = 7;
	localparam int FracFldW = 12;
	localparam int RecipW   = 17;

	// config register indexes
	typedef enum logic [0:0] {
		CFG_PFD     = 1'b0,
		CFG_SPACING = 1'b1
	} cfg_reg_t;

	localparam logic [CfgW-1:0] PFD_RESET     = 16'd25000;
	localparam logic [CfgW-1:0] SPACING_RESET = 16'd100;
	localparam logic [CfgW-1:0] KHZ_PER_MHZ   = 16'd1000;

	// pfd / 1000 as (pfd * ceil(2^26 / 1000)) >> 26, exact for 16-bit pfd
	localparam logic [RecipW-1:0] MHZ_RECIP    = 17'd67109;
	localparam int                MHZ_RECIP_SH = 26;

	// output divider band edges, kHz
	localparam logic [FreqW-1:0] BAND_0_KHZ = 23'd2200000;
	localparam logic [FreqW-1:0] BAND_1_KHZ = 23'd1100000;
	localparam logic [FreqW-1:0] BAND_2_KHZ = 23'd550000;
	localparam logic [FreqW-1:0] BAND_3_KHZ = 23'd275000;
	localparam logic [FreqW-1:0] BAND_4_KHZ = 23'd137500;
	localparam logic [FreqW-1:0] BAND_5_KHZ = 23'd68750;

	// fixed register words and bases
	localparam logic [WordW-1:0] REG1_BASE = 32'h0000_8001;
	localparam logic [WordW-1:0] REG2_WORD = 32'h0000_4E42;
	localparam logic [WordW-1:0] REG3_WORD = 32'h0000_04B3;
	localparam logic [WordW-1:0] REG4_BASE = 32'h0085_03FC;
	localparam logic [WordW-1:0] REG5_WORD = 32'h0058_0005;

	// register numbers
	localparam logic [IdxW-1:0] RIDX_0 = 3'd0;
	localparam logic [IdxW-1:0] RIDX_1 = 3'd1;
	localparam logic [IdxW-1:0] RIDX_2 = 3'd2;
	localparam logic [IdxW-1:0] RIDX_3 = 3'd3;
	localparam logic [IdxW-1:0] RIDX_4 = 3'd4;
	localparam logic [IdxW-1:0] RIDX_5 = 3'd5;

	// divider iteration counts
	localparam logic [DivCntW-1:0] NB_CFG  = 6'd16;
	localparam logic [DivCntW-1:0] NB_INT  = 6'd23;
	localparam logic [DivCntW-1:0] NB_FRAC = 6'd32;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_DIV_PFDK,
		OP_SET_MODNUM,
		OP_DIV_MODNUM,
		OP_SET_MOD,
		OP_DIV_INT,
		OP_SET_INT,
		OP_ZERO_INT,
		OP_SET_MPROD,
		OP_DIV_FRAC,
		OP_SET_FRAC,
		OP_GCD_INIT,
		OP_DIV_GCD,
		OP_GCD_STEP,
		OP_DIV_MODG,
		OP_SET_MODG,
		OP_DIV_FRACG,
		OP_SET_FRACG,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic            load;
		dp_op_t          op;
		logic [IdxW-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic pfd_zero;
		logic spacing_zero;
		logic gb_zero;
		logic g_gt1;
	} dp_sts_t;

endpackage

>>> design/fnsrc_div.sv
// Restoring divider, one quotient bit per cycle.
`include "frac_n_synth_register_calc_unit_macros.svh"

module fnsrc_div import fnsrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DivW-1:0]    dividend,
	input  logic [CfgW-1:0]    divisor,
	input  logic [DivCntW-1:0] nbits,
	output logic               done,
	output logic [DivW-1:0]    quo,
	output logic [CfgW-1:0]    rem
);

	logic               run_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivW-1:0]    quo_q;
	logic [CfgW-1:0]    rem_q;
	logic [CfgW-1:0]    dvs_q;
	logic [CfgW:0]      trial;
	logic [CfgW:0]      diff;
	logic               fits;

	assign trial = {rem_q, quo_q[DivW-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= nbits;
		end else begin
			done_q <= run_q && (cnt_q == DivCntW'(1));
			if (run_q) begin
				cnt_q <= cnt_q - DivCntW'(1);
				if (cnt_q == DivCntW'(1)) run_q <= 1'b0;
			end
		end
	end

	// dividend is pre-shifted so its top bit leads
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend << (DivCntW'(DivW) - nbits);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DivW-2:0], fits};
			rem_q <= fits ? diff[CfgW-1:0] : trial[CfgW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	`FNSRC_ASSERT_NOW(a_div_start_idle, start, !run_q, "divider restarted mid-run")
	`FNSRC_ASSERT_NOW(a_div_done_stopped, done_q, !run_q && (cnt_q == '0), "done while running")

endmodule

>>> design/fnsrc_dp.sv
// Datapath: config registers, operand registers, divider and output word register.
`include "frac_n_synth_register_calc_unit_macros.svh"

module fnsrc_dp import fnsrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [FreqW-1:0] freq_khz,
	input  logic             wr_en,
	input  logic [0:0]       wr_index,
	input  logic [CfgW-1:0]  wr_data,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output logic             word_valid,
	output logic [IdxW-1:0]  reg_index,
	output logic [WordW-1:0] reg_word,
	output logic             last_word
);

	logic [CfgW-1:0]        pfd_q;
	logic [CfgW-1:0]        spacing_q;
	logic [BandW-1:0]       band_in;
	logic [BandW-1:0]       band_q;
	logic [FreqW-1:0]       prod_q;
	logic [CfgW+RecipW-1:0] pfd_scaled;
	logic [MhzW-1:0]        pfd_mhz_q;
	logic [CfgW-1:0]        modnum_q;
	logic [CfgW-1:0]        mod_q;
	logic [CfgW-1:0]        int_q;
	logic [CfgW-1:0]        rem_q;
	logic [DivW-1:0]        mprod_q;
	logic [CfgW-1:0]        frac_q;
	logic [CfgW-1:0]        ga_q;
	logic [CfgW-1:0]        gb_q;
	logic                   div_start;
	logic [DivW-1:0]        div_dividend;
	logic [CfgW-1:0]        div_divisor;
	logic [DivCntW-1:0]     div_nbits;
	logic                   div_done;
	logic [DivW-1:0]        div_quo;
	logic [CfgW-1:0]        div_rem;
	logic [WordW-1:0]       word_d;
	logic                   word_valid_q;
	logic [IdxW-1:0]        reg_index_q;
	logic [WordW-1:0]       reg_word_q;
	logic                   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfd_q     <= PFD_RESET;
			spacing_q <= SPACING_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_PFD:     pfd_q     <= wr_data;
				CFG_SPACING: spacing_q <= wr_data;
				default: ;
			endcase
		end
	end

	// divider band, log2 of the output divider
	always_comb begin
		priority if (freq_khz >= BAND_0_KHZ) band_in = 3'd0;
		else if (freq_khz >= BAND_1_KHZ) band_in = 3'd1;
		else if (freq_khz >= BAND_2_KHZ) band_in = 3'd2;
		else if (freq_khz >= BAND_3_KHZ) band_in = 3'd3;
		else if (freq_khz >= BAND_4_KHZ) band_in = 3'd4;
		else if (freq_khz >= BAND_5_KHZ) band_in = 3'd5;
		else band_in = 3'd6;
	end

	// pfd in whole MHz by reciprocal multiply
	assign pfd_scaled = (CfgW+RecipW)'(pfd_q) * (CfgW+RecipW)'(MHZ_RECIP);

	// divider operand select
	always_comb begin
		div_start    = 1'b1;
		div_dividend = '0;
		div_divisor  = KHZ_PER_MHZ;
		div_nbits    = NB_CFG;
		unique case (cmd.op)
			OP_DIV_MODNUM: begin
				div_dividend = DivW'(modnum_q);
				div_divisor  = spacing_q;
			end
			OP_DIV_INT: begin
				div_dividend = DivW'(prod_q);
				div_divisor  = pfd_q;
				div_nbits    = NB_INT;
			end
			OP_DIV_FRAC: begin
				div_dividend = mprod_q;
				div_divisor  = pfd_q;
				div_nbits    = NB_FRAC;
			end
			OP_DIV_GCD: begin
				div_dividend = DivW'(ga_q);
				div_divisor  = gb_q;
			end
			OP_DIV_MODG: begin
				div_dividend = DivW'(mod_q);
				div_divisor  = ga_q;
			end
			OP_DIV_FRACG: begin
				div_dividend = DivW'(frac_q);
				div_divisor  = ga_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	fnsrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			band_q <= band_in;
			prod_q <= freq_khz << band_in;
		end
		unique case (cmd.op)
			OP_DIV_PFDK:   pfd_mhz_q <= pfd_scaled[MHZ_RECIP_SH +: MhzW];
			OP_SET_MODNUM: modnum_q  <= CfgW'(pfd_mhz_q) * KHZ_PER_MHZ;
			OP_SET_MOD:    mod_q     <= sts.spacing_zero ? '0 : div_quo[CfgW-1:0];
			OP_SET_INT: begin
				int_q <= div_quo[CfgW-1:0];
				rem_q <= div_rem;
			end
			OP_ZERO_INT: begin
				int_q  <= '0;
				frac_q <= '0;
			end
			OP_SET_MPROD: mprod_q <= DivW'(rem_q) * DivW'(mod_q);
			OP_SET_FRAC:  frac_q  <= div_quo[CfgW-1:0];
			OP_GCD_INIT: begin
				ga_q <= frac_q;
				gb_q <= mod_q;
			end
			OP_GCD_STEP: begin
				ga_q <= gb_q;
				gb_q <= div_rem;
			end
			OP_SET_MODG:  mod_q  <= div_quo[CfgW-1:0];
			OP_SET_FRACG: frac_q <= div_quo[CfgW-1:0];
			default: ;
		endcase
	end

	always_comb begin
		unique case (cmd.idx)
			RIDX_0:  word_d = {1'b0, int_q, frac_q[FracFldW-1:0], 3'b000};
			RIDX_1:  word_d = REG1_BASE | {13'd0, mod_q, 3'b000};
			RIDX_2:  word_d = REG2_WORD;
			RIDX_3:  word_d = REG3_WORD;
			RIDX_4:  word_d = REG4_BASE + {9'd0, band_q, 20'd0};
			RIDX_5:  word_d = REG5_WORD;
			default: word_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) word_valid_q <= 1'b0;
		else word_valid_q <= (cmd.op == OP_EMIT);
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			reg_index_q <= cmd.idx;
			reg_word_q  <= word_d;
			last_q      <= (cmd.idx == RIDX_0);
		end
	end

	assign sts.div_done     = div_done;
	assign sts.pfd_zero     = (pfd_q == '0);
	assign sts.spacing_zero = (spacing_q == '0);
	assign sts.gb_zero      = (gb_q == '0);
	assign sts.g_gt1        = (ga_q > CfgW'(1));

	assign word_valid = word_valid_q;
	assign reg_index  = reg_index_q;
	assign reg_word   = reg_word_q;
	assign last_word  = last_q;

	`FNSRC_ASSERT_NOW(a_div_nonzero, div_start, div_divisor != '0, "division by zero issued")

endmodule

>>> design/fnsrc_ctrl.sv
// Sequencer: steps the datapath through the divisions, the GCD loop and word output.
`include "frac_n_synth_register_calc_unit_macros.svh"

module fnsrc_ctrl import fnsrc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MODQ,
		ST_MODQ_W,
		ST_MODN,
		ST_MODN_W,
		ST_INT,
		ST_INT_W,
		ST_MPROD,
		ST_FRAC,
		ST_FRAC_W,
		ST_GINIT,
		ST_GCHK,
		ST_GCD,
		ST_GCD_W,
		ST_RED,
		ST_MODG_W,
		ST_FRACG,
		ST_FRACG_W,
		ST_EMIT
	} state_t;

	state_t          state_q;
	dp_op_t          op_q;
	logic [IdxW-1:0] idx_q;
	logic [IdxW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NONE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			op_q <= OP_NONE;
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_MODQ;
				ST_MODQ: begin
					op_q    <= OP_DIV_PFDK;
					state_q <= ST_MODQ_W;
				end
				// pfd in MHz is registered while this state runs
				ST_MODQ_W: begin
					op_q    <= OP_SET_MODNUM;
					state_q <= ST_MODN;
				end
				ST_MODN: if (sts.spacing_zero) begin
					op_q    <= OP_SET_MOD;
					state_q <= ST_INT;
				end else begin
					op_q    <= OP_DIV_MODNUM;
					state_q <= ST_MODN_W;
				end
				ST_MODN_W: if (sts.div_done) begin
					op_q    <= OP_SET_MOD;
					state_q <= ST_INT;
				end
				ST_INT: if (sts.pfd_zero) begin
					op_q    <= OP_ZERO_INT;
					state_q <= ST_GINIT;
				end else begin
					op_q    <= OP_DIV_INT;
					state_q <= ST_INT_W;
				end
				ST_INT_W: if (sts.div_done) begin
					op_q    <= OP_SET_INT;
					state_q <= ST_MPROD;
				end
				ST_MPROD: begin
					op_q    <= OP_SET_MPROD;
					state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					op_q    <= OP_DIV_FRAC;
					state_q <= ST_FRAC_W;
				end
				ST_FRAC_W: if (sts.div_done) begin
					op_q    <= OP_SET_FRAC;
					state_q <= ST_GINIT;
				end
				ST_GINIT: begin
					op_q    <= OP_GCD_INIT;
					state_q <= ST_GCHK;
				end
				ST_GCHK: state_q <= ST_GCD;
				ST_GCD: if (sts.gb_zero) begin
					state_q <= ST_RED;
				end else begin
					op_q    <= OP_DIV_GCD;
					state_q <= ST_GCD_W;
				end
				ST_GCD_W: if (sts.div_done) begin
					op_q    <= OP_GCD_STEP;
					state_q <= ST_GCHK;
				end
				ST_RED: if (sts.g_gt1) begin
					op_q    <= OP_DIV_MODG;
					state_q <= ST_MODG_W;
				end else begin
					cnt_q   <= RIDX_5;
					state_q <= ST_EMIT;
				end
				ST_MODG_W: if (sts.div_done) begin
					op_q    <= OP_SET_MODG;
					state_q <= ST_FRACG;
				end
				ST_FRACG: begin
					op_q    <= OP_DIV_FRACG;
					state_q <= ST_FRACG_W;
				end
				ST_FRACG_W: if (sts.div_done) begin
					op_q    <= OP_SET_FRACG;
					cnt_q   <= RIDX_5;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					op_q  <= OP_EMIT;
					idx_q <= cnt_q;
					if (cnt_q == RIDX_0) state_q <= ST_IDLE;
					else cnt_q <= cnt_q - IdxW'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.op   = op_q;
	assign cmd.idx  = idx_q;

	`FNSRC_ASSERT_NOW(a_done_in_wait, sts.div_done,
		state_q == ST_MODQ_W || state_q == ST_MODN_W || state_q == ST_INT_W ||
		state_q == ST_FRAC_W || state_q == ST_GCD_W || state_q == ST_MODG_W ||
		state_q == ST_FRACG_W, "divider finished outside a wait state")
	`FNSRC_ASSERT_NEXT(a_emit_ends, (state_q == ST_EMIT) && (cnt_q == RIDX_0),
		(state_q == ST_IDLE) && (op_q == OP_EMIT) && (idx_q == RIDX_0),
		"word run did not end on register 0")

endmodule

>>> design/frac_n_synth_register_calc_unit.sv
// Top level of the fractional-N synthesizer register calculator.
//
// Usage
//   Input: raise start with freq_khz (wanted RF output in kHz); the transaction
//   is taken on a rising edge where start is high and busy is low. busy stays
//   high until the register-0 word is being loaded into the output register.
//   Output: six transactions, registers 5,4,3,2,1,0 in that order, one per
//   cycle on consecutive cycles, each marked by word_valid for one cycle;
//   last_word flags register 0. The receiver cannot stall: words are shown
//   once and must be taken.
//   Config: wr_en/wr_index/wr_data write pfd_khz (index 0) or
//   channel_spacing_khz (index 1); write only while busy is low.
// Timing
//   pfd in whole MHz comes from a reciprocal multiply; MOD, INT, FRAC, the
//   Euclid remainders and the reduction share one bit-serial divider; zero
//   spacing skips the MOD division and zero pfd the INT and FRAC divisions.
//   The six words follow back to back. busy drops in the cycle before the
//   register-0 word shows, and the next transaction can be taken at the first
//   edge with busy low.
// Reset
//   arst_n (async, active low) returns the sequencer to idle, drops
//   word_valid and loads pfd 25000 kHz and spacing 100 kHz.

module frac_n_synth_register_calc_unit import fnsrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [FreqW-1:0] freq_khz,
	input  logic             wr_en,
	input  logic [0:0]       wr_index,
	input  logic [CfgW-1:0]  wr_data,
	output logic             word_valid,
	output logic [IdxW-1:0]  reg_index,
	output logic [WordW-1:0] reg_word,
	output logic             last_word
);

	// command from sequencer, status back from datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer: MOD, then INT/remainder, then FRAC, then Euclid on FRAC/MOD,
	// optional reduction, then the six-word output run.
	fnsrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// Datapath: holds config, operands, the shared divider and the output
	// word register; freq_khz is captured on the accepting edge.
	fnsrc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.freq_khz   (freq_khz),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.cmd        (cmd),
		.sts        (sts),
		.word_valid (word_valid),
		.reg_index  (reg_index),
		.reg_word   (reg_word),
		.last_word  (last_word)
	);

endmodule
